[rtl/dpe_pkg.sv]
// Shared types and constants for the dipole pair energy accumulator.
package dpe_pkg;

    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int TOP_W   = 92;
    localparam int DEN_W   = 80;
    localparam int REM_W   = 81;
    localparam int Q_W     = 32;
    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;

    // multiply program
    localparam logic [STEP_W-1:0] ST_LEN2  = 5'd0;
    localparam logic [STEP_W-1:0] ST_AB_X  = 5'd1;
    localparam logic [STEP_W-1:0] ST_AB_Y  = 5'd2;
    localparam logic [STEP_W-1:0] ST_AB_Z  = 5'd3;
    localparam logic [STEP_W-1:0] ST_AR_X  = 5'd4;
    localparam logic [STEP_W-1:0] ST_AR_Y  = 5'd5;
    localparam logic [STEP_W-1:0] ST_AR_Z  = 5'd6;
    localparam logic [STEP_W-1:0] ST_BR_X  = 5'd7;
    localparam logic [STEP_W-1:0] ST_BR_Y  = 5'd8;
    localparam logic [STEP_W-1:0] ST_BR_Z  = 5'd9;
    localparam logic [STEP_W-1:0] ST_R4    = 5'd10;
    localparam logic [STEP_W-1:0] ST_NUM_A = 5'd11;
    localparam logic [STEP_W-1:0] ST_NUM_B = 5'd12;
    localparam logic [STEP_W-1:0] ST_DEN_L = 5'd13;
    localparam logic [STEP_W-1:0] ST_DEN_H = 5'd14;
    localparam logic [STEP_W-1:0] ST_TOP_L = 5'd15;
    localparam logic [STEP_W-1:0] ST_TOP_H = 5'd16;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_DIVGO  = 6'b001000,
        S_DIVRUN = 6'b010000,
        S_RES    = 6'b100000
    } t_state;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_st;

endpackage

[rtl/dpe_mul.sv]
// Shared registered signed multiplier.
module dpe_mul
    import dpe_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[rtl/dpe_div.sv]
// Restoring serial divider, one quotient bit per cycle, with overflow check.
module dpe_div
    import dpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TOP_W-1:0] i_top,
    input  logic [DEN_W-1:0] i_den,
    output t_div_st          o_st,
    output logic [Q_W-1:0]   o_q
);

    logic [REM_W-1:0] r_rem;
    logic [7:0]       r_lowb;
    logic [Q_W-1:0]   r_q;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_ovf;
    logic [REM_W-1:0] n_sh;
    logic             n_ge;

    assign n_sh = {r_rem[REM_W-2:0], r_lowb[7]};
    assign n_ge = n_sh >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_top[88:8];
            r_lowb <= i_top[7:0];
            r_q    <= '0;
            r_ovf  <= i_top >= {4'b0, i_den, 8'b0};
        end else if (r_busy) begin
            r_lowb <= {r_lowb[6:0], 1'b0};
            r_rem  <= n_ge ? n_sh - {1'b0, i_den} : n_sh;
            r_q    <= {r_q[Q_W-2:0], n_ge};
        end
    end

    assign o_st.done = r_done;
    assign o_st.ovf  = r_ovf;
    assign o_q       = r_q;

endmodule

[rtl/dipole_pair_energy_accumulate.sv]
// Dipole pair energy accumulator: sequencer, datapath registers and total.
// Use: one particle pair per input item on the valid/stall input channel;
// one result item per pair on the valid/stall output channel.
// o_in_stall is low only while the block is idle; each pair then runs a
// seventeen-step program on one shared 33x33 multiplier, then a drain state,
// a divider start and a restoring serial divider for the division by R^5;
// no new item is accepted until the result of the last one is passed to the
// output register. A finished result sits in the output register until
// taken; the next pair may be accepted meanwhile, but its own result waits
// while the receiver stalls the earlier one.
// Pairs with zero length or length above the cutoff give energy zero.
// The running total saturates at 40 bits and clears after a pair marked
// last. Configuration writes (cutoff, scale) are taken any cycle and should
// be made while idle.
// Reset (synchronous, active low) empties the block, clears the total and
// loads cutoff 8.0 and scale 1.0.
module dipole_pair_energy_accumulate
    import dpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_moment_a_x,
    input  logic signed [15:0]   i_moment_a_y,
    input  logic signed [15:0]   i_moment_a_z,
    input  logic signed [15:0]   i_moment_b_x,
    input  logic signed [15:0]   i_moment_b_y,
    input  logic signed [15:0]   i_moment_b_z,
    input  logic signed [15:0]   i_sep_x,
    input  logic signed [15:0]   i_sep_y,
    input  logic signed [15:0]   i_sep_z,
    input  logic [15:0]          i_sep_length,
    input  logic                 i_last_pair,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_pair_energy,
    output logic signed [39:0]   o_running_total,
    output logic                 o_total_done
);

    t_state r_state;
    logic [15:0] r_cutoff;
    logic [31:0] r_scale;
    logic signed [15:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_rx, r_ry, r_rz;
    logic [15:0] r_len;
    logic        r_last;
    logic        r_zero;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] r_act;
    logic        r_act_v;
    logic signed [34:0] r_acc;
    logic signed [22:0] r_dab, r_dar, r_dbr;
    logic [31:0] r_len2;
    logic [63:0] r_r4;
    logic signed [60:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [TOP_W-1:0] r_top;
    logic signed [39:0] r_sum;
    logic        r_out_v;
    logic signed [31:0] r_e_out;
    logic signed [39:0] r_t_out;
    logic        r_d_out;

    logic signed [MUL_W-1:0]  n_a, n_b;
    logic signed [PROD_W-1:0] w_p;
    logic signed [34:0] n_dsum;
    logic [34:0]        n_dabs;
    logic signed [22:0] n_dtr;
    logic [59:0]        n_mag;
    logic signed [48:0] n_tri;
    t_div_st            w_dst;
    logic [Q_W-1:0]     w_q;
    logic [32:0]        n_lim, n_qm;
    logic signed [32:0] n_e;
    logic signed [40:0] n_s;
    logic signed [39:0] n_sat;
    logic               n_take;

    function automatic logic signed [MUL_W-1:0] sx(input logic signed [15:0] v);
        return MUL_W'(v);
    endfunction

    assign n_mag = r_num[60] ? 60'(-r_num) : 60'(r_num);

    always_comb begin
        n_a = '0;
        n_b = '0;
        case (r_step)
            ST_LEN2:  begin n_a = {17'b0, r_len}; n_b = {17'b0, r_len}; end
            ST_AB_X:  begin n_a = sx(r_ax); n_b = sx(r_bx); end
            ST_AB_Y:  begin n_a = sx(r_ay); n_b = sx(r_by); end
            ST_AB_Z:  begin n_a = sx(r_az); n_b = sx(r_bz); end
            ST_AR_X:  begin n_a = sx(r_ax); n_b = sx(r_rx); end
            ST_AR_Y:  begin n_a = sx(r_ay); n_b = sx(r_ry); end
            ST_AR_Z:  begin n_a = sx(r_az); n_b = sx(r_rz); end
            ST_BR_X:  begin n_a = sx(r_bx); n_b = sx(r_rx); end
            ST_BR_Y:  begin n_a = sx(r_by); n_b = sx(r_ry); end
            ST_BR_Z:  begin n_a = sx(r_bz); n_b = sx(r_rz); end
            ST_R4:    begin n_a = {1'b0, r_len2}; n_b = {1'b0, r_len2}; end
            ST_NUM_A: begin n_a = {1'b0, r_len2}; n_b = MUL_W'(r_dab); end
            ST_NUM_B: begin n_a = MUL_W'(r_dar); n_b = MUL_W'(r_dbr); end
            ST_DEN_L: begin n_a = {1'b0, r_r4[31:0]}; n_b = {17'b0, r_len}; end
            ST_DEN_H: begin n_a = {1'b0, r_r4[63:32]}; n_b = {17'b0, r_len}; end
            ST_TOP_L: begin n_a = {1'b0, n_mag[31:0]}; n_b = {1'b0, r_scale}; end
            ST_TOP_H: begin n_a = {5'b0, n_mag[59:32]}; n_b = {1'b0, r_scale}; end
            default:  begin n_a = '0; n_b = '0; end
        endcase
    end

    dpe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (n_a),
        .i_b   (n_b),
        .o_p   (w_p)
    );

    dpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_top   (r_top),
        .i_den   (r_den),
        .o_st    (w_dst),
        .o_q     (w_q)
    );

    // dot product close: add last term, truncate toward zero to Q.12
    assign n_dsum = r_acc + w_p[34:0];
    assign n_dabs = n_dsum[34] ? 35'(-n_dsum) : 35'(n_dsum);
    assign n_dtr  = n_dsum[34] ? 23'(-$signed({1'b0, n_dabs[34:12]}))
                               : $signed({1'b0, n_dabs[33:12]});
    assign n_tri  = $signed(w_p[48:0]) + $signed({w_p[47:0], 1'b0});

    // saturation and total
    assign n_lim = r_num[60] ? 33'h080000000 : 33'h07FFFFFFF;
    assign n_qm  = (w_dst.ovf || {1'b0, w_q} > n_lim) ? n_lim : {1'b0, w_q};
    assign n_e   = r_zero ? '0 : (r_num[60] ? -$signed(n_qm) : $signed(n_qm));
    assign n_s   = 41'(r_sum) + 41'(n_e);
    assign n_sat = (n_s > 41'sh7FFFFFFFFF) ? 40'sh7FFFFFFFFF :
                   (n_s < -41'sh8000000000) ? -40'sh8000000000 : n_s[39:0];
    assign n_take = (r_state == S_RES) && (!r_out_v || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cutoff <= 16'd32768;
            r_scale  <= 32'd65536;
            r_sum    <= '0;
            r_out_v  <= 1'b0;
            r_act_v  <= 1'b0;
            r_step   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CUTOFF: r_cutoff <= i_cfg_data[15:0];
                    CFG_SCALE:  r_scale  <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (n_take) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                        r_step  <= ST_LEN2;
                    end
                end
                S_MUL: begin
                    r_act   <= r_step;
                    r_act_v <= 1'b1;
                    r_step  <= r_step + STEP_W'(1);
                    if (r_step == ST_TOP_H) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    r_act_v <= 1'b0;
                    r_state <= S_DIVGO;
                end
                S_DIVGO: r_state <= S_DIVRUN;
                S_DIVRUN: begin
                    if (w_dst.done) r_state <= S_RES;
                end
                S_RES: begin
                    if (n_take) begin
                        r_sum   <= r_last ? '0 : n_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_ax   <= i_moment_a_x;
            r_ay   <= i_moment_a_y;
            r_az   <= i_moment_a_z;
            r_bx   <= i_moment_b_x;
            r_by   <= i_moment_b_y;
            r_bz   <= i_moment_b_z;
            r_rx   <= i_sep_x;
            r_ry   <= i_sep_y;
            r_rz   <= i_sep_z;
            r_len  <= i_sep_length;
            r_last <= i_last_pair;
            r_zero <= (i_sep_length == 16'd0) || (i_sep_length > r_cutoff);
        end
        if (r_act_v) begin
            case (r_act)
                ST_LEN2: r_len2 <= w_p[31:0];
                ST_AB_X, ST_AR_X, ST_BR_X: r_acc <= w_p[34:0];
                ST_AB_Y, ST_AR_Y, ST_BR_Y: r_acc <= n_dsum;
                ST_AB_Z:  r_dab <= n_dtr;
                ST_AR_Z:  r_dar <= n_dtr;
                ST_BR_Z:  r_dbr <= n_dtr;
                ST_R4:    r_r4  <= w_p[63:0];
                ST_NUM_A: r_num <= w_p[60:0];
                ST_NUM_B: r_num <= r_num - $signed({n_tri, 12'b0});
                ST_DEN_L: r_den <= DEN_W'(w_p[47:0]);
                ST_DEN_H: r_den <= r_den + {w_p[47:0], 32'b0};
                ST_TOP_L: r_top <= TOP_W'(w_p[63:0]);
                ST_TOP_H: r_top <= r_top + {w_p[59:0], 32'b0};
                default:  ;
            endcase
        end
        if (n_take) begin
            r_e_out <= n_e[31:0];
            r_t_out <= n_sat;
            r_d_out <= r_last;
        end
    end

    assign o_in_stall      = r_state != S_IDLE;
    assign o_out_valid     = r_out_v;
    assign o_pair_energy   = r_e_out;
    assign o_running_total = r_t_out;
    assign o_total_done    = r_d_out;

endmodule

[dv/tb_dipole_pair_energy_accumulate.sv]
// Testbench for the dipole pair energy accumulator, checked against a predictor.
`timescale 1ns / 100ps

class dpe_scoreboard;
    logic [15:0] cutoff;
    logic [31:0] scale;
    logic signed [39:0] energy_sum;
    logic signed [31:0] want_energy[$];
    logic signed [39:0] want_total[$];
    logic want_done[$];
    int errors;
    int results;

    function new();
        cutoff = 16'd32768;
        scale = 32'd65536;
        energy_sum = '0;
        errors = 0;
        results = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == dpe_pkg::CFG_CUTOFF) begin
            cutoff = val[15:0];
        end else if (idx == dpe_pkg::CFG_SCALE) begin
            scale = val;
        end
    endfunction

    function automatic longint trunc_q12(longint x);
        if (x < 0) return -((-x) >>> 12);
        return x >>> 12;
    endfunction

    function automatic logic signed [31:0] pair_energy(logic signed [15:0] m[9],
                                                       logic [15:0] len);
        longint dab, dar, dbr;
        logic signed [127:0] num;
        logic [127:0] mag, top, den, q;
        logic neg;
        if (len == 0 || len > cutoff) return '0;
        dab = trunc_q12(longint'(m[0]) * m[3] + longint'(m[1]) * m[4]
                        + longint'(m[2]) * m[5]);
        dar = trunc_q12(longint'(m[0]) * m[6] + longint'(m[1]) * m[7]
                        + longint'(m[2]) * m[8]);
        dbr = trunc_q12(longint'(m[3]) * m[6] + longint'(m[4]) * m[7]
                        + longint'(m[5]) * m[8]);
        num = 128'(longint'(len) * len) * 128'(dab)
              - 128'(dar) * 128'(dbr) * 128'(3 * 4096);
        neg = num < 0;
        mag = neg ? -num : num;
        top = (mag * 128'(scale)) << 24;
        den = 128'(len) * len * len * len * len;
        q = top / den;
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return -32'(q);
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return 32'(q);
    endfunction

    function void note_pair(logic signed [15:0] m[9], logic [15:0] len, logic last);
        logic signed [31:0] e;
        logic signed [41:0] s;
        e = pair_energy(m, len);
        s = 42'(energy_sum) + 42'(e);
        if (s > 42'sh7F_FFFF_FFFF) s = 42'sh7F_FFFF_FFFF;
        if (s < -42'sh80_0000_0000) s = -42'sh80_0000_0000;
        want_energy.push_back(e);
        want_total.push_back(40'(s));
        want_done.push_back(last);
        energy_sum = last ? '0 : 40'(s);
    endfunction

    function void check_result(logic signed [31:0] e, logic signed [39:0] t, logic d);
        results++;
        if (want_energy.size() == 0) begin
            $error("result with nothing expected: energy %0d", e);
            errors++;
            return;
        end
        if (want_energy[0] !== e) begin
            $error("pair_energy expected %0d actual %0d", want_energy[0], e);
            errors++;
        end
        if (want_total[0] !== t) begin
            $error("running_total expected %0d actual %0d", want_total[0], t);
            errors++;
        end
        if (want_done[0] !== d) begin
            $error("total_done expected %0d actual %0d", want_done[0], d);
            errors++;
        end
        void'(want_energy.pop_front());
        void'(want_total.pop_front());
        void'(want_done.pop_front());
    endfunction
endclass

module tb_dipole_pair_energy_accumulate;
    import dpe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 0, o_in_stall;
    logic signed [15:0] pin[9];
    logic [15:0] i_sep_length = '0;
    logic i_last_pair = 0;
    logic o_out_valid, i_out_stall = 1;
    logic signed [31:0] o_pair_energy;
    logic signed [39:0] o_running_total;
    logic o_total_done;

    int send_idle = 0, recv_idle = 0;
    bit hold_off = 0;
    longint cycles = 0;
    dpe_scoreboard sb = new();

    initial foreach (pin[i]) pin[i] = '0;

    always #2 i_clk = ~i_clk;

    dipole_pair_energy_accumulate dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_stall,
        .i_moment_a_x(pin[0]), .i_moment_a_y(pin[1]), .i_moment_a_z(pin[2]),
        .i_moment_b_x(pin[3]), .i_moment_b_y(pin[4]), .i_moment_b_z(pin[5]),
        .i_sep_x(pin[6]), .i_sep_y(pin[7]), .i_sep_z(pin[8]),
        .i_sep_length, .i_last_pair,
        .o_out_valid, .i_out_stall,
        .o_pair_energy, .o_running_total, .o_total_done
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_pair_energy, o_running_total, o_total_done);
            i_out_stall <= hold_off || ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_pair(pin, i_sep_length, i_last_pair);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // valid stays high after an accept; a later idle or drain() drops it
    task automatic send_pair(logic signed [15:0] m[9], logic [15:0] len, logic last);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        foreach (m[i]) pin[i] <= m[i];
        i_sep_length <= len;
        i_last_pair <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.want_energy.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(8192)) - 16'sd4096;
            default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    task automatic random_pair(int mode);
        logic signed [15:0] m[9];
        logic [15:0] len;
        foreach (m[i]) m[i] = rand_comp($urandom_range(9) == 0 ? 2 : mode);
        case ($urandom_range(9))
            0: len = 16'($urandom);
            1: len = sb.cutoff;
            2: len = sb.cutoff + 16'd1;
            3: len = '0;
            4: len = 16'($urandom_range(200, 1));
            default: len = 16'($urandom_range(16384, 1024));
        endcase
        send_pair(m, len, $urandom_range(15) == 0);
    endtask

    initial begin
        logic signed [15:0] m[9];
        int phase;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed pairs
        foreach (m[i]) m[i] = 16'sh1000;
        send_pair(m, 16'h1000, 0);
        send_pair(m, 16'h0000, 0);
        send_pair(m, 16'd32768, 0);
        send_pair(m, 16'd32769, 0);
        send_pair(m, 16'hFFFF, 0);
        send_pair(m, 16'd1, 0);
        foreach (m[i]) m[i] = 16'sh7FFF;
        send_pair(m, 16'd1, 0);
        send_pair(m, 16'd1, 0);
        foreach (m[i]) m[i] = 16'sh8000;
        m[0] = 16'sh7FFF;
        send_pair(m, 16'd1, 0);
        send_pair(m, 16'd1, 1);
        foreach (m[i]) m[i] = (i < 3) ? 16'sh8000 : 16'sh7FFF;
        for (int k = 0; k < 6; k++) send_pair(m, 16'd1, k == 5);
        foreach (m[i]) m[i] = '0;
        send_pair(m, 16'd4096, 1);
        drain();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_CUTOFF, 32'hFFFF_FFFF);
                    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
                end
                1: begin write_reg(CFG_CUTOFF, 32'd0); write_reg(CFG_SCALE, 32'd0); end
                2: begin
                    write_reg(CFG_CUTOFF, 32'd16384);
                    write_reg(CFG_SCALE, 32'd12345);
                end
                3: write_reg(CFG_NONE, 32'hDEAD_BEEF);
                4: begin write_reg(CFG_CUTOFF, $urandom); write_reg(CFG_SCALE, $urandom); end
                default: begin
                    write_reg(CFG_CUTOFF, 32'd32768);
                    write_reg(CFG_SCALE, 32'd65536);
                end
            endcase
            send_idle = (phase < 2) ? 15 : (phase < 4) ? 55 : 0;
            recv_idle = (phase < 2) ? 55 : (phase < 4) ? 15 : 0;
            for (int k = 0; k < 270; k++) random_pair(k % 3 == 0 ? 1 : 0);
            if (phase == 4) begin
                fork
                    begin hold_off = 1; repeat (600) @(posedge i_clk); hold_off = 0; end
                    for (int k = 0; k < 8; k++) random_pair(0);
                join
            end
            drain();
        end

        $display("Covered %0d results over six register settings, with idles, long stalls",
                 sb.results);
        $display("and zero-length, cutoff-edge, saturating and last-pair cases.");
        if (sb.errors == 0 && sb.want_energy.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
